/* hw/rtl/midpoint_ellipse_point_generator_assert.svh */
// Assertion macros for the ellipse generator RTL, used by the sequencer.
`ifndef MIDPOINT_ELLIPSE_POINT_GENERATOR_ASSERT_SVH
`define MIDPOINT_ELLIPSE_POINT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MEPG_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
`define MEPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEPG_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define MEPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/mepg_pkg.sv */
package mepg_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int PT_W            = 13;
    localparam int CTR_W           = 12;
    localparam int CFG_IDX_W       = 1;
    localparam int UPC_W           = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {MA_RX, MA_RY, MA_RXSQ, MA_RYSQ, MA_TX, MA_TY} ma_sel_t;
    typedef enum logic [2:0] {MB_RX, MB_RY, MB_TX, MB_TY, MB_RYSQ, MB_PROD} mb_sel_t;
    typedef enum logic [3:0] {
        DO_NONE, DO_LOAD_RXSQ, DO_LOAD_PROD, DO_ADD_RXSQ4, DO_ADD_RYSQ4,
        DO_ADD_SX4, DO_SUB_SY4, DO_ADD_PROD4, DO_SUB_PROD4
    } dec_op_t;
    typedef enum logic [1:0] {XO_HOLD, XO_ZERO, XO_INC} x_op_t;
    typedef enum logic [1:0] {YO_HOLD, YO_LOAD, YO_DEC} y_op_t;
    typedef enum logic [1:0] {SXO_HOLD, SXO_ZERO, SXO_ADD} sx_op_t;
    typedef enum logic [1:0] {SYO_HOLD, SYO_LOAD, SYO_SUB} sy_op_t;
    typedef enum logic [1:0] {R2_HOLD, R2_CLEAR, R2_SET} r2_op_t;
    typedef enum logic [2:0] {CD_NEVER, CD_ALWAYS, CD_DEC_NEG, CD_DEC_LE0, CD_NOT_LESS} cond_t;
    typedef enum logic [1:0] {EM_NONE, EM_POINT, EM_NULL} emit_t;

    typedef struct packed {
        ma_sel_t ma;
        mb_sel_t mb;
        logic    mul_en;
        dec_op_t dec_op;
        x_op_t   x_op;
        y_op_t   y_op;
        sx_op_t  sx_op;
        sy_op_t  sy_op;
        logic    rxsq_ld;
        logic    rysq_ld;
        r2_op_t  r2_op;
        cond_t   cond;
        upc_t    target;
        emit_t   emit;
    } ctrl_t;

    typedef struct packed {
        logic dec_neg;
        logic dec_zero;
        logic sx_lt_sy;
        logic y_zero;
        logic region2;
    } stat_t;

    // Microprogram addresses
    localparam upc_t U_START0 = 5'd0;
    localparam upc_t U_START1 = 5'd1;
    localparam upc_t U_START2 = 5'd2;
    localparam upc_t U_START3 = 5'd3;
    localparam upc_t U_START4 = 5'd4;
    localparam upc_t U_R1_TEST = 5'd5;
    localparam upc_t U_R1_S1  = 5'd6;
    localparam upc_t U_R1_S2  = 5'd7;
    localparam upc_t U_R1_S3  = 5'd8;
    localparam upc_t U_R1_NEG = 5'd9;
    localparam upc_t U_E0     = 5'd10;
    localparam upc_t U_E1     = 5'd11;
    localparam upc_t U_E2     = 5'd12;
    localparam upc_t U_E3     = 5'd13;
    localparam upc_t U_E4     = 5'd14;
    localparam upc_t U_E5     = 5'd15;
    localparam upc_t U_R2A    = 5'd16;
    localparam upc_t U_R2B    = 5'd17;
    localparam upc_t U_R2X    = 5'd18;
    localparam upc_t U_R2Y    = 5'd19;
    localparam upc_t U_NULL   = 5'd20;
    localparam upc_t U_LAST   = U_NULL;

    function automatic ctrl_t ctrl_idle();
        ctrl_t w;
        w.ma      = MA_RX;
        w.mb      = MB_RX;
        w.mul_en  = 1'b0;
        w.dec_op  = DO_NONE;
        w.x_op    = XO_HOLD;
        w.y_op    = YO_HOLD;
        w.sx_op   = SXO_HOLD;
        w.sy_op   = SYO_HOLD;
        w.rxsq_ld = 1'b0;
        w.rysq_ld = 1'b0;
        w.r2_op   = R2_HOLD;
        w.cond    = CD_NEVER;
        w.target  = U_START0;
        w.emit    = EM_NONE;
        return w;
    endfunction

    // Control store. Decision terms are scaled by four throughout.
    function automatic ctrl_t micro_word(upc_t upc);
        ctrl_t w;
        w = ctrl_idle();
        unique case (upc)
            U_START0:
            begin
                w.mul_en = 1'b1; w.ma = MA_RX; w.mb = MB_RX;
            end
            U_START1:
            begin
                w.rxsq_ld = 1'b1;
                w.mul_en = 1'b1; w.ma = MA_RY; w.mb = MB_RY;
                w.x_op = XO_ZERO; w.y_op = YO_LOAD; w.sx_op = SXO_ZERO;
                w.r2_op = R2_CLEAR;
            end
            U_START2:
            begin
                w.rysq_ld = 1'b1;
                w.mul_en = 1'b1; w.ma = MA_RXSQ; w.mb = MB_RY;
                w.dec_op = DO_LOAD_RXSQ;
            end
            U_START3:
            begin
                w.sy_op = SYO_LOAD; w.dec_op = DO_SUB_PROD4;
            end
            U_START4:
            begin
                w.dec_op = DO_ADD_RYSQ4; w.emit = EM_POINT;
            end
            U_R1_TEST:
            begin
                w.cond = CD_NOT_LESS; w.target = U_E0;
            end
            U_R1_S1:
            begin
                w.x_op = XO_INC; w.sx_op = SXO_ADD; w.dec_op = DO_ADD_RYSQ4;
                w.cond = CD_DEC_NEG; w.target = U_R1_NEG;
            end
            U_R1_S2:
            begin
                w.y_op = YO_DEC; w.sy_op = SYO_SUB; w.dec_op = DO_ADD_SX4;
            end
            U_R1_S3:
            begin
                w.dec_op = DO_SUB_SY4; w.emit = EM_POINT;
            end
            U_R1_NEG:
            begin
                w.dec_op = DO_ADD_SX4; w.emit = EM_POINT;
            end
            U_E0:
            begin
                w.mul_en = 1'b1; w.ma = MA_TX; w.mb = MB_TX;
            end
            U_E1:
            begin
                w.mul_en = 1'b1; w.ma = MA_RYSQ; w.mb = MB_PROD;
            end
            U_E2:
            begin
                w.dec_op = DO_LOAD_PROD;
                w.mul_en = 1'b1; w.ma = MA_TY; w.mb = MB_TY;
            end
            U_E3:
            begin
                w.mul_en = 1'b1; w.ma = MA_RXSQ; w.mb = MB_PROD;
            end
            U_E4:
            begin
                w.dec_op = DO_ADD_PROD4;
                w.mul_en = 1'b1; w.ma = MA_RXSQ; w.mb = MB_RYSQ;
            end
            U_E5:
            begin
                w.dec_op = DO_SUB_PROD4; w.r2_op = R2_SET;
                w.cond = CD_ALWAYS; w.target = U_R2A;
            end
            U_R2A:
            begin
                w.y_op = YO_DEC; w.sy_op = SYO_SUB; w.dec_op = DO_ADD_RXSQ4;
                w.cond = CD_DEC_LE0; w.target = U_R2X;
            end
            U_R2B:
            begin
                w.dec_op = DO_SUB_SY4; w.emit = EM_POINT;
            end
            U_R2X:
            begin
                w.x_op = XO_INC; w.sx_op = SXO_ADD; w.dec_op = DO_SUB_SY4;
            end
            U_R2Y:
            begin
                w.dec_op = DO_ADD_SX4; w.emit = EM_POINT;
            end
            U_NULL:
            begin
                w.emit = EM_NULL;
            end
            default:
            begin
                w.emit = EM_NULL;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/mepg_if.sv */
interface mepg_req_if #(parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, req_type, radius_x, radius_y, input ready);
    modport sink   (input valid, req_type, radius_x, radius_y, output ready);
endinterface

interface mepg_pt_if;
    import mepg_pkg::*;

    logic            valid;
    logic            ready;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic            point_valid;
    logic            last_point;

    modport source (output valid, point_x, point_y, point_valid, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_valid, last_point, output ready);
endinterface

/* hw/rtl/mepg_datapath.sv */
module mepg_datapath #(
    parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_radii,
    input  logic [RADIUS_BITS-1:0] radius_x,
    input  logic [RADIUS_BITS-1:0] radius_y,
    input  mepg_pkg::ctrl_t        ctrl,
    output mepg_pkg::stat_t        stat,
    output logic [RADIUS_BITS:0]   cur_x,
    output logic [RADIUS_BITS-1:0] cur_y
);
    import mepg_pkg::*;

    localparam int X_W   = RADIUS_BITS + 1;
    localparam int Y_W   = RADIUS_BITS;
    localparam int SQ_W  = 2 * RADIUS_BITS;
    localparam int SL_W  = 3 * RADIUS_BITS + 4;
    // terms wrap at DEC_W bits (at most 64), as two's complement
    localparam int DEC_W = (4 * RADIUS_BITS + 4 > 64) ? 64 : 4 * RADIUS_BITS + 4;
    localparam int MA_W  = 2 * RADIUS_BITS;
    localparam int MB_W  = 2 * RADIUS_BITS + 4;
    localparam int MP_W  = MA_W + MB_W;

    logic [Y_W-1:0]   rad_x_reg, rad_x_next, rad_y_reg, rad_y_next;
    logic [X_W-1:0]   x_reg, x_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [SQ_W-1:0]  rxsq_reg, rxsq_next, rysq_reg, rysq_next;
    logic [SL_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [DEC_W-1:0] dec_reg, dec_next;
    logic [DEC_W-1:0] prod_reg, prod_next;
    logic             r2_reg, r2_next;

    logic [X_W:0]     tx;
    logic [Y_W-1:0]   ty;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [MP_W-1:0]  prod_full;
    logic [DEC_W-1:0] dec_opnd, dec_base;
    logic             dec_sub, dec_load, dec_en;

    assign tx = {x_reg, 1'b1};
    assign ty = y_reg - Y_W'(1);

    always_comb
    begin
        unique case (ctrl.ma)
            MA_RX:   mul_a = MA_W'(rad_x_reg);
            MA_RY:   mul_a = MA_W'(rad_y_reg);
            MA_RXSQ: mul_a = rxsq_reg;
            MA_RYSQ: mul_a = rysq_reg;
            MA_TX:   mul_a = MA_W'(tx);
            MA_TY:   mul_a = MA_W'(ty);
            default: mul_a = '0;
        endcase
        unique case (ctrl.mb)
            MB_RX:   mul_b = MB_W'(rad_x_reg);
            MB_RY:   mul_b = MB_W'(rad_y_reg);
            MB_TX:   mul_b = MB_W'(tx);
            MB_TY:   mul_b = MB_W'(ty);
            MB_RYSQ: mul_b = MB_W'(rysq_reg);
            MB_PROD: mul_b = prod_reg[MB_W-1:0];
            default: mul_b = '0;
        endcase
    end

    assign prod_full = MP_W'(mul_a) * MP_W'(mul_b);
    assign prod_next = ctrl.mul_en ? prod_full[DEC_W-1:0] : prod_reg;

    always_comb
    begin
        dec_opnd = '0;
        dec_sub  = 1'b0;
        dec_load = 1'b0;
        dec_en   = 1'b1;
        unique case (ctrl.dec_op)
            DO_NONE:      dec_en = 1'b0;
            DO_LOAD_RXSQ:
            begin
                dec_load = 1'b1;
                dec_opnd = DEC_W'(rxsq_reg);
            end
            DO_LOAD_PROD:
            begin
                dec_load = 1'b1;
                dec_opnd = prod_reg;
            end
            DO_ADD_RXSQ4: dec_opnd = DEC_W'({rxsq_reg, 2'b00});
            DO_ADD_RYSQ4: dec_opnd = DEC_W'({rysq_reg, 2'b00});
            DO_ADD_SX4:   dec_opnd = DEC_W'({sx_reg, 2'b00});
            DO_SUB_SY4:
            begin
                dec_sub  = 1'b1;
                dec_opnd = DEC_W'({sy_reg, 2'b00});
            end
            DO_ADD_PROD4: dec_opnd = DEC_W'({prod_reg, 2'b00});
            DO_SUB_PROD4:
            begin
                dec_sub  = 1'b1;
                dec_opnd = DEC_W'({prod_reg, 2'b00});
            end
            default:      dec_en = 1'b0;
        endcase
    end

    assign dec_base = dec_load ? '0 : dec_reg;
    assign dec_next = !dec_en ? dec_reg
                    : (dec_sub ? dec_base - dec_opnd : dec_base + dec_opnd);

    always_comb
    begin
        unique case (ctrl.x_op)
            XO_ZERO: x_next = '0;
            XO_INC:  x_next = x_reg + X_W'(1);
            default: x_next = x_reg;
        endcase
        unique case (ctrl.y_op)
            YO_LOAD: y_next = rad_y_reg;
            YO_DEC:  y_next = y_reg - Y_W'(1);
            default: y_next = y_reg;
        endcase
        unique case (ctrl.sx_op)
            SXO_ZERO: sx_next = '0;
            SXO_ADD:  sx_next = sx_reg + SL_W'({rysq_reg, 1'b0});
            default:  sx_next = sx_reg;
        endcase
        unique case (ctrl.sy_op)
            SYO_LOAD: sy_next = SL_W'({prod_reg, 1'b0});
            SYO_SUB:  sy_next = sy_reg - SL_W'({rxsq_reg, 1'b0});
            default:  sy_next = sy_reg;
        endcase
        unique case (ctrl.r2_op)
            R2_CLEAR: r2_next = 1'b0;
            R2_SET:   r2_next = 1'b1;
            default:  r2_next = r2_reg;
        endcase
    end

    assign rxsq_next  = ctrl.rxsq_ld ? prod_reg[SQ_W-1:0] : rxsq_reg;
    assign rysq_next  = ctrl.rysq_ld ? prod_reg[SQ_W-1:0] : rysq_reg;
    assign rad_x_next = load_radii ? radius_x : rad_x_reg;
    assign rad_y_next = load_radii ? radius_y : rad_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_reg <= 1'b0;
        end
        else
        begin
            r2_reg <= r2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_x_reg <= rad_x_next;
        rad_y_reg <= rad_y_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rxsq_reg  <= rxsq_next;
        rysq_reg  <= rysq_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        dec_reg   <= dec_next;
        prod_reg  <= prod_next;
    end

    assign stat.dec_neg  = dec_reg[DEC_W-1];
    assign stat.dec_zero = (dec_reg == '0);
    assign stat.sx_lt_sy = (sx_reg < sy_reg);
    assign stat.y_zero   = (y_reg == '0);
    assign stat.region2  = r2_reg;

    assign cur_x = x_reg;
    assign cur_y = y_reg;

endmodule

/* hw/rtl/mepg_sequencer.sv */
`include "midpoint_ellipse_point_generator_assert.svh"

module mepg_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic            req_type,
    input  mepg_pkg::stat_t stat,
    input  logic            out_free,
    output mepg_pkg::ctrl_t ctrl,
    output logic            load_radii
);
    import mepg_pkg::*;

    logic  busy_reg, busy_next;
    logic  active_reg, active_next;
    upc_t  upc_reg, upc_next;
    ctrl_t word;
    upc_t  entry;
    logic  accept, stall, step, cond_true;

    assign word      = micro_word(upc_reg);
    // an emitting word waits for room in the output register
    assign stall     = (word.emit != EM_NONE) && !out_free;
    assign step      = busy_reg && !stall;
    assign ctrl      = step ? word : ctrl_idle();
    assign req_ready = !busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign load_radii = accept && (req_type == REQ_START);

    always_comb
    begin
        unique case (word.cond)
            CD_NEVER:    cond_true = 1'b0;
            CD_ALWAYS:   cond_true = 1'b1;
            CD_DEC_NEG:  cond_true = stat.dec_neg;
            CD_DEC_LE0:  cond_true = stat.dec_neg || stat.dec_zero;
            CD_NOT_LESS: cond_true = !stat.sx_lt_sy;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (req_type == REQ_START)
            entry = U_START0;
        else if (active_reg)
            entry = stat.region2 ? U_R2A : U_R1_TEST;
        else
            entry = U_NULL;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        upc_next    = upc_reg;
        active_next = active_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = entry;
        end
        else if (step)
        begin
            if (word.emit != EM_NONE)
            begin
                busy_next = 1'b0;
                if (word.emit == EM_POINT)
                    active_next = !stat.y_zero;
            end
            else if (cond_true)
                upc_next = word.target;
            else
                upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            active_reg <= 1'b0;
            upc_reg    <= U_START0;
        end
        else
        begin
            busy_reg   <= busy_next;
            active_reg <= active_next;
            upc_reg    <= upc_next;
        end
    end

    `MEPG_ASSERT_IMPL(a_accept_busy, clk, rst_n, req_valid && req_ready, busy_reg, "accepted transaction did not start the sequencer")
    `MEPG_ASSERT_IMPL(a_stall_hold, clk, rst_n, busy_reg && stall, busy_reg && $stable(upc_reg), "stalled microword moved on")
    `MEPG_ASSERT_ALWAYS(a_upc_range, clk, rst_n, !busy_reg || upc_reg <= U_LAST, "microprogram counter outside control store")
    `MEPG_ASSERT_IMPL(a_active_last, clk, rst_n, step && word.emit == EM_POINT, active_reg == !$past(stat.y_zero), "active flag disagrees with last point")

endmodule

/* hw/rtl/midpoint_ellipse_point_generator.sv */
// Midpoint ellipse point generator, first quadrant.
// req (valid/ready): req_type 0 starts an ellipse with radius_x/radius_y and
// returns the top point (0, ry); req_type 1 returns the next point of the arc.
// pt (valid/ready): one transaction per request. point_valid is 0 for a step
// while no ellipse is running; last_point marks the point with y = 0.
// cfg_we/cfg_index/cfg_data write center_x (0) and center_y (1), added to
// every point modulo 2^13. Write them only while the block is idle.
// A microcoded sequencer drives one registered multiplier and one decision
// adder, one control word per cycle unless an emitting word waits for the
// output register. The step that crosses into region two also recomputes
// the decision term; a step while idle only emits a null point.
// req.ready is low from acceptance until the result is loaded; the next
// request is then accepted while the result still waits on pt.
// If pt stalls with a result pending, the next request runs up to its
// emitting control word and holds there until the output register frees.
// Reset clears the centre offsets, the sequencer and the output valid flag;
// the block comes up idle with no ellipse running.
module midpoint_ellipse_point_generator #(
    parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mepg_req_if.sink                       req,
    mepg_pt_if.source                      pt,
    input  logic                           cfg_we,
    input  logic [mepg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mepg_pkg::CTR_W-1:0]     cfg_data
);
    import mepg_pkg::*;

    localparam int XS_W = ((RADIUS_BITS + 1 > CTR_W) ? RADIUS_BITS + 1 : CTR_W) + 1;
    localparam int YS_W = ((RADIUS_BITS > CTR_W) ? RADIUS_BITS : CTR_W) + 1;

    logic [CTR_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic             out_valid_reg, out_valid_next;
    logic [PT_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic             pv_reg, pv_next, last_reg, last_next;

    ctrl_t                  ctrl;
    stat_t                  stat;
    logic                   load_radii;
    logic                   out_free;
    logic [RADIUS_BITS:0]   cur_x;
    logic [RADIUS_BITS-1:0] cur_y;
    logic [XS_W-1:0]        sum_x;
    logic [YS_W-1:0]        sum_y;

    mepg_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_type   (req.req_type),
        .stat       (stat),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .load_radii (load_radii)
    );

    mepg_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_radii (load_radii),
        .radius_x   (RADIUS_BITS'(req.radius_x)),
        .radius_y   (RADIUS_BITS'(req.radius_y)),
        .ctrl       (ctrl),
        .stat       (stat),
        .cur_x      (cur_x),
        .cur_y      (cur_y)
    );

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: cx_next = cfg_data;
                CFG_CENTER_Y: cy_next = cfg_data;
            endcase
        end
    end

    assign out_free = !out_valid_reg || pt.ready;
    assign sum_x    = XS_W'(cur_x) + XS_W'(cx_reg);
    assign sum_y    = YS_W'(cur_y) + YS_W'(cy_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pv_next        = pv_reg;
        last_next      = last_reg;
        unique case (ctrl.emit)
            EM_POINT:
            begin
                out_valid_next = 1'b1;
                px_next        = sum_x[PT_W-1:0];
                py_next        = sum_y[PT_W-1:0];
                pv_next        = 1'b1;
                last_next      = stat.y_zero;
            end
            EM_NULL:
            begin
                out_valid_next = 1'b1;
                px_next        = '0;
                py_next        = '0;
                pv_next        = 1'b0;
                last_next      = 1'b0;
            end
            default:
            begin
                if (pt.ready)
                    out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pv_reg   <= pv_next;
        last_reg <= last_next;
    end

    assign pt.valid       = out_valid_reg;
    assign pt.point_x     = px_reg;
    assign pt.point_y     = py_reg;
    assign pt.point_valid = pv_reg;
    assign pt.last_point  = last_reg;

endmodule

/* bench/tb_midpoint_ellipse_point_generator.sv */
`timescale 1ns / 100ps

module tb_midpoint_ellipse_point_generator;
    import mepg_pkg::*;

    localparam int RAD_W       = RADIUS_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [PT_W-1:0] px;
        logic [PT_W-1:0] py;
        logic            pv;
        logic            last;
    } point_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CTR_W-1:0]     cfg_data;

    mepg_req_if #(.RADIUS_BITS(RAD_W)) req_bus ();
    mepg_pt_if                         pt_bus ();

    midpoint_ellipse_point_generator #(.RADIUS_BITS(RAD_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .pt        (pt_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_t expected_points[$];
    int     errors       = 0;
    int     items_sent   = 0;
    int     cycle_count  = 0;
    int     hold_request = 0;
    bit     gaps_on      = 1'b1;

    // Arc tracer state: decision terms are kept scaled by four, 64-bit wrap
    logic [CTR_W-1:0] ctr_x;
    logic [CTR_W-1:0] ctr_y;
    logic [63:0]      pos_x;
    logic [63:0]      pos_y;
    logic [63:0]      rx_sq;
    logic [63:0]      ry_sq;
    logic [63:0]      span_x;
    logic [63:0]      span_y;
    logic [63:0]      err_term;
    bit               in_second;
    bit               tracing;

    function automatic point_t trace_point(logic kind, logic [RAD_W-1:0] rx_in,
                                           logic [RAD_W-1:0] ry_in);
        point_t      p;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] tx;
        logic [63:0] ty;
        bit          emits;
        p     = '0;
        emits = 1'b1;
        if (kind == REQ_START)
        begin
            rx        = 64'(rx_in);
            ry        = 64'(ry_in);
            rx_sq     = rx * rx;
            ry_sq     = ry * ry;
            pos_x     = '0;
            pos_y     = ry;
            span_x    = '0;
            span_y    = 64'd2 * rx_sq * ry;
            err_term  = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
            in_second = 1'b0;
            tracing   = (ry != 0);
        end
        else if (!tracing)
        begin
            emits = 1'b0;
        end
        else
        begin
            if (!in_second && span_x < span_y)
            begin
                pos_x  = pos_x + 1;
                span_x = span_x + 64'd2 * ry_sq;
                if (err_term[63])
                    err_term = err_term + 64'd4 * (span_x + ry_sq);
                else
                begin
                    pos_y    = pos_y - 1;
                    span_y   = span_y - 64'd2 * rx_sq;
                    err_term = err_term + 64'd4 * (span_x - span_y + ry_sq);
                end
            end
            else
            begin
                // slope crossed: recompute the decision term at the region seam
                if (!in_second)
                begin
                    tx        = 64'd2 * pos_x + 1;
                    ty        = pos_y - 1;
                    err_term  = ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty
                              - 64'd4 * rx_sq * ry_sq;
                    in_second = 1'b1;
                end
                pos_y  = pos_y - 1;
                span_y = span_y - 64'd2 * rx_sq;
                if (!err_term[63] && err_term != 0)
                    err_term = err_term + 64'd4 * (rx_sq - span_y);
                else
                begin
                    pos_x    = pos_x + 1;
                    span_x   = span_x + 64'd2 * ry_sq;
                    err_term = err_term + 64'd4 * (span_x - span_y + rx_sq);
                end
            end
            if (pos_y == 0)
                tracing = 1'b0;
        end
        if (emits)
        begin
            p.px   = PT_W'(pos_x + 64'(ctr_x));
            p.py   = PT_W'(pos_y + 64'(ctr_y));
            p.pv   = 1'b1;
            p.last = (pos_y == 0);
        end
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [PT_W-1:0] want,
                                        logic [PT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold when a test asks for one
    initial
    begin
        int stall_left;
        stall_left = 0;
        pt_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                pt_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pt_bus.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && pt_bus.valid && pt_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point transaction with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("point_x", want.px, pt_bus.point_x);
                check_field("point_y", want.py, pt_bus.point_y);
                check_field("point_valid", PT_W'(want.pv), PT_W'(pt_bus.point_valid));
                check_field("last_point", PT_W'(want.last), PT_W'(pt_bus.last_point));
            end
        end
    end

    task automatic send_req(logic kind, logic [RAD_W-1:0] rx, logic [RAD_W-1:0] ry);
        int     gap;
        point_t p;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.radius_x <= rx;
        req_bus.radius_y <= ry;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        p = trace_point(kind, rx, ry);
        expected_points.insert(expected_points.size(), p);
        items_sent++;
    endtask

    task automatic send_step();
        send_req(REQ_STEP, RAD_W'($urandom), RAD_W'($urandom));
    endtask

    // Start an arc, follow it for up to max_steps, then step past the end if it finished
    task automatic trace_ellipse(logic [RAD_W-1:0] rx, logic [RAD_W-1:0] ry,
                                 int max_steps, int extra);
        int n;
        n = 0;
        send_req(REQ_START, rx, ry);
        while (tracing && n < max_steps)
        begin
            send_step();
            n++;
        end
        if (!tracing)
            repeat (extra) send_step();
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_centre(logic [CTR_W-1:0] x, logic [CTR_W-1:0] y);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CENTER_X;
        cfg_data  <= x;
        @(posedge clk);
        cfg_index <= CFG_CENTER_Y;
        cfg_data  <= y;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ctr_x = x;
        ctr_y = y;
    endtask

    task automatic test_idle_steps();
        send_step();
        send_step();
    endtask

    task automatic test_corner_shapes();
        trace_ellipse(10'd5, 10'd0, 0, 1);        // flat: top point is also the last
        trace_ellipse(10'd0, 10'd3, 100, 1);      // degenerate: straight down x = 0
        trace_ellipse(10'd0, 10'd0, 0, 0);
        trace_ellipse(10'd1023, 10'd1023, 3, 0);  // abandoned by the next start
        trace_ellipse(10'd1, 10'd1, 100, 1);
        trace_ellipse(10'd1023, 10'd1, 4, 0);
        trace_ellipse(10'd1, 10'd1023, 3, 0);
    endtask

    task automatic test_random_arcs(int quota);
        int base;
        int r;
        base = items_sent;
        while (items_sent - base < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 3)) send_step();
            end
            else if (r < 78)
                trace_ellipse(RAD_W'($urandom_range(0, 40)), RAD_W'($urandom_range(0, 40)),
                              1 << 20, $urandom_range(0, 2));
            else if (r < 88)
                trace_ellipse(RAD_W'($urandom_range(0, 200)), RAD_W'($urandom_range(0, 200)),
                              $urandom_range(20, 80), $urandom_range(0, 2));
            else
                trace_ellipse(RAD_W'($urandom), RAD_W'($urandom),
                              $urandom_range(5, 40), 1);
        end
    endtask

    task automatic test_back_pressure();
        hold_request = 400;
        trace_ellipse(10'd30, 10'd20, 1 << 20, 1);
    endtask

    initial
    begin
        clk   = 1'b0;
        rst_n <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_START;
        req_bus.radius_x <= '0;
        req_bus.radius_y <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CENTER_X;
        cfg_data  <= '0;
        ctr_x     = '0;
        ctr_y     = '0;
        pos_x     = '0;
        pos_y     = '0;
        rx_sq     = '0;
        ry_sq     = '0;
        span_x    = '0;
        span_y    = '0;
        err_term  = '0;
        in_second = 1'b0;
        tracing   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_steps();
        test_corner_shapes();
        wait_drained();

        write_centre(12'd4095, 12'd4095);
        test_random_arcs(300);
        wait_drained();

        gaps_on = 1'b0;
        write_centre(12'd0, 12'd4095);
        test_random_arcs(200);
        wait_drained();

        gaps_on = 1'b1;
        write_centre(CTR_W'($urandom_range(0, 4095)), CTR_W'($urandom_range(0, 4095)));
        test_back_pressure();
        test_random_arcs(300);
        wait_drained();

        write_centre(12'd4095, 12'd0);
        test_random_arcs(400);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
